### rtl/core/hrle_pkg.sv
// Shared types and constants for the RLE scanline decoder.
`default_nettype none
package hrle_pkg;

  // Largest supported scanline width (pixels).
  localparam int unsigned MAX_WIDTH_DEF = 32767;
  localparam int unsigned MIN_WIDTH     = 8;

  // Marker byte that opens every scanline (twice).
  localparam logic [7:0] MARKER_BYTE = 8'd2;
  // Codes above this value are runs, the rest literals.
  localparam logic [7:0] RUN_BASE    = 8'd128;

  // Result codes.
  localparam logic [2:0] RES_PIXEL      = 3'd0;
  localparam logic [2:0] RES_BAD_MARKER = 3'd1;
  localparam logic [2:0] RES_BAD_RUN    = 3'd2;
  localparam logic [2:0] RES_BAD_LIT    = 3'd3;
  localparam logic [2:0] RES_BYTE_DRAIN = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_MARKER,
    ST_CODE,
    ST_RUN,
    ST_FILL,
    ST_LIT,
    ST_DRAIN,
    ST_RDWAIT,
    ST_HALT
  } state_e;

  // Request to the shared column adder/comparator.
  typedef struct packed {
    logic [14:0] a;
    logic [7:0]  b;
  } colu_req_t;

  // Its answer: sum and compares of the sum against the row width.
  typedef struct packed {
    logic [15:0] sum;
    logic        ge;
    logic        gt;
  } colu_rsp_t;

  // Line store access, one write channel select per plane.
  typedef struct packed {
    logic [3:0]  we;
    logic [14:0] waddr;
    logic [7:0]  wdata;
    logic [14:0] raddr;
  } store_req_t;

endpackage
`default_nettype wire

### rtl/core/hrle_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hrle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/hrle_col_unit.sv
// Shared column adder with compares against the effective row width.
`default_nettype none
module hrle_col_unit (
  input  wire logic                 [14:0] width_i,
  input  wire hrle_pkg::colu_req_t         req_i,
  output hrle_pkg::colu_rsp_t              rsp_o
);

  logic [15:0] sum;

  assign sum       = {1'b0, req_i.a} + {8'd0, req_i.b};
  assign rsp_o.sum = sum;
  assign rsp_o.ge  = sum >= {1'b0, width_i};
  assign rsp_o.gt  = sum >  {1'b0, width_i};

endmodule
`default_nettype wire

### rtl/core/hrle_ctrl.sv
// Decode sequencer: marker check, run/literal fill, row drain, result register.
`default_nettype none
module hrle_ctrl #(
  parameter int unsigned MAX_WIDTH = hrle_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic           [14:0] cfg_data_i,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_kind_i,
  input  wire logic           [7:0]  in_byte_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                [2:0]  out_err_o,
  output logic                [7:0]  out_red_o,
  output logic                [7:0]  out_green_o,
  output logic                [7:0]  out_blue_o,
  output logic                [7:0]  out_exp_o,
  output logic                [14:0] out_col_o,
  output logic                [14:0] out_row_o,
  output logic                       out_lr_o,
  output logic                       out_li_o,
  // shared column unit
  output logic                [14:0] colu_width_o,
  output hrle_pkg::colu_req_t        colu_req_o,
  input  wire hrle_pkg::colu_rsp_t   colu_rsp_i,
  // line store
  output hrle_pkg::store_req_t       store_o,
  input  wire logic           [31:0] store_rdata_i
);

  localparam logic [14:0] MaxW = 15'(MAX_WIDTH);
  localparam logic [14:0] MinW = 15'(hrle_pkg::MIN_WIDTH);

  hrle_pkg::state_e state_q, state_d;

  logic [14:0] width_q, height_q;
  logic [23:0] mbytes_q, mbytes_d;
  logic [1:0]  mcnt_q, mcnt_d;
  logic [1:0]  ch_q, ch_d;
  logic [14:0] wcol_q, wcol_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  val_q, val_d;
  logic [14:0] dcol_q, dcol_d;
  logic [14:0] row_q, row_d;

  // drain staging and result register
  logic [14:0] scol_q, scol_d, srow_q, srow_d;
  logic        slr_q, slr_d, sli_q, sli_d;
  logic        ov_q, ov_d;
  logic [2:0]  oerr_q, oerr_d;
  logic [31:0] orgbe_q, orgbe_d;
  logic [14:0] ocol_q, ocol_d, orow_q, orow_d;
  logic        olr_q, olr_d, oli_q, oli_d;

  logic [14:0] eff_w, eff_h;
  logic        acc, is_byte, is_tick;
  logic        is_run;
  logic [7:0]  code_cnt;
  logic        marker_ok;
  logic        code_err;
  logic        last_write;
  logic [15:0] row_inc;
  logic        lr, li;
  logic        accepting;

  // effective image geometry
  always_comb begin
    eff_w = width_q;
    if (width_q < MinW) eff_w = MinW;
    if (width_q > MaxW) eff_w = MaxW;
    eff_h = (height_q == 15'd0) ? 15'd1 : height_q;
  end

  assign colu_width_o = eff_w;

  // handshake
  assign accepting  = (state_q != hrle_pkg::ST_FILL) && (state_q != hrle_pkg::ST_RDWAIT);
  assign in_ready_o = accepting && (!ov_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign is_byte    = acc && (in_kind_i == hrle_pkg::KIND_BYTE);
  assign is_tick    = acc && (in_kind_i == hrle_pkg::KIND_TICK);
  assign cfg_ready_o = 1'b1;

  // code and marker decode
  assign is_run    = in_byte_i > hrle_pkg::RUN_BASE;
  assign code_cnt  = is_run ? (in_byte_i - hrle_pkg::RUN_BASE) : in_byte_i;
  assign marker_ok = (mbytes_q[23:16] == hrle_pkg::MARKER_BYTE)
                  && (mbytes_q[15:8] == hrle_pkg::MARKER_BYTE)
                  && ({mbytes_q[7:0], in_byte_i} == {1'b0, eff_w});
  assign code_err  = colu_rsp_i.gt || (!is_run && code_cnt == 8'd0);
  assign last_write = pend_q == 8'd1;

  // drain flags
  assign row_inc = {1'b0, row_q} + 16'd1;
  assign lr      = colu_rsp_i.ge;
  assign li      = lr && (row_inc >= {1'b0, eff_h});

  // shared column unit operands
  always_comb begin
    colu_req_o.a = wcol_q;
    colu_req_o.b = 8'd1;
    case (state_q)
      hrle_pkg::ST_CODE:  colu_req_o.b = code_cnt;
      hrle_pkg::ST_DRAIN: colu_req_o.a = dcol_q;
      default: ;
    endcase
  end

  // line store port
  always_comb begin
    store_o.we    = 4'd0;
    store_o.waddr = wcol_q;
    store_o.wdata = val_q;
    store_o.raddr = dcol_q;
    if (state_q == hrle_pkg::ST_LIT) store_o.wdata = in_byte_i;
    if (wcol_q < MaxW) begin
      if (state_q == hrle_pkg::ST_FILL || (state_q == hrle_pkg::ST_LIT && is_byte)) begin
        store_o.we[ch_q] = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hrle_pkg::ST_MARKER: begin
        if (is_byte && mcnt_q == 2'd3) begin
          state_d = marker_ok ? hrle_pkg::ST_CODE : hrle_pkg::ST_HALT;
        end
      end
      hrle_pkg::ST_CODE: begin
        if (is_byte) begin
          if (code_err) state_d = hrle_pkg::ST_HALT;
          else if (is_run) state_d = hrle_pkg::ST_RUN;
          else state_d = hrle_pkg::ST_LIT;
        end
      end
      hrle_pkg::ST_RUN: begin
        if (is_byte) state_d = hrle_pkg::ST_FILL;
      end
      hrle_pkg::ST_FILL, hrle_pkg::ST_LIT: begin
        if ((state_q == hrle_pkg::ST_FILL || is_byte) && last_write) begin
          state_d = (colu_rsp_i.ge && ch_q == 2'd3) ? hrle_pkg::ST_DRAIN : hrle_pkg::ST_CODE;
        end
      end
      hrle_pkg::ST_DRAIN: begin
        if (is_tick) state_d = hrle_pkg::ST_RDWAIT;
        else if (is_byte) state_d = hrle_pkg::ST_HALT;
      end
      hrle_pkg::ST_RDWAIT: begin
        state_d = slr_q ? hrle_pkg::ST_MARKER : hrle_pkg::ST_DRAIN;
      end
      hrle_pkg::ST_HALT: state_d = hrle_pkg::ST_HALT;
      default: state_d = hrle_pkg::ST_HALT;
    endcase
  end

  // datapath registers and results
  always_comb begin
    mbytes_d = mbytes_q;
    mcnt_d   = mcnt_q;
    ch_d     = ch_q;
    wcol_d   = wcol_q;
    pend_d   = pend_q;
    val_d    = val_q;
    dcol_d   = dcol_q;
    row_d    = row_q;
    scol_d   = scol_q;
    srow_d   = srow_q;
    slr_d    = slr_q;
    sli_d    = sli_q;
    ov_d     = ov_q && !out_ready_i;
    oerr_d   = oerr_q;
    orgbe_d  = orgbe_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    olr_d    = olr_q;
    oli_d    = oli_q;

    case (state_q)
      hrle_pkg::ST_MARKER: begin
        if (is_byte) begin
          if (mcnt_q != 2'd3) begin
            mbytes_d = {mbytes_q[15:0], in_byte_i};
            mcnt_d   = mcnt_q + 2'd1;
          end else begin
            mcnt_d   = 2'd0;
            mbytes_d = 24'd0;
            if (marker_ok) begin
              ch_d   = 2'd0;
              wcol_d = 15'd0;
            end else begin
              ov_d   = 1'b1;
              oerr_d = hrle_pkg::RES_BAD_MARKER;
            end
          end
        end
      end
      hrle_pkg::ST_CODE: begin
        if (is_byte) begin
          pend_d = code_cnt;
          if (code_err) begin
            ov_d   = 1'b1;
            oerr_d = is_run ? hrle_pkg::RES_BAD_RUN : hrle_pkg::RES_BAD_LIT;
          end
        end
      end
      hrle_pkg::ST_RUN: begin
        if (is_byte) val_d = in_byte_i;
      end
      hrle_pkg::ST_FILL, hrle_pkg::ST_LIT: begin
        if (state_q == hrle_pkg::ST_FILL || is_byte) begin
          wcol_d = colu_rsp_i.sum[14:0];
          pend_d = pend_q - 8'd1;
          if (last_write && colu_rsp_i.ge) begin
            wcol_d = 15'd0;
            if (ch_q == 2'd3) begin
              ch_d   = 2'd0;
              dcol_d = 15'd0;
            end else begin
              ch_d = ch_q + 2'd1;
            end
          end
        end
      end
      hrle_pkg::ST_DRAIN: begin
        if (is_tick) begin
          scol_d = dcol_q;
          srow_d = row_q;
          slr_d  = lr;
          sli_d  = li;
          if (lr) begin
            row_d    = li ? 15'd0 : row_inc[14:0];
            dcol_d   = 15'd0;
            mbytes_d = 24'd0;
            mcnt_d   = 2'd0;
          end else begin
            dcol_d = colu_rsp_i.sum[14:0];
          end
        end else if (is_byte) begin
          ov_d   = 1'b1;
          oerr_d = hrle_pkg::RES_BYTE_DRAIN;
        end
      end
      hrle_pkg::ST_RDWAIT: begin
        ov_d    = 1'b1;
        oerr_d  = hrle_pkg::RES_PIXEL;
        orgbe_d = store_rdata_i;
        ocol_d  = scol_q;
        orow_d  = srow_q;
        olr_d   = slr_q;
        oli_d   = sli_q;
      end
      default: ;
    endcase

    // error results carry nothing but the code
    if (ov_d && !ov_q && oerr_d != hrle_pkg::RES_PIXEL) begin
      orgbe_d = 32'd0;
      ocol_d  = 15'd0;
      orow_d  = 15'd0;
      olr_d   = 1'b0;
      oli_d   = 1'b0;
    end else if (ov_d && ov_q && out_ready_i && oerr_d != hrle_pkg::RES_PIXEL) begin
      orgbe_d = 32'd0;
      ocol_d  = 15'd0;
      orow_d  = 15'd0;
      olr_d   = 1'b0;
      oli_d   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hrle_pkg::ST_MARKER;
      width_q  <= MinW;
      height_q <= 15'd1;
      mbytes_q <= 24'd0;
      mcnt_q   <= 2'd0;
      ch_q     <= 2'd0;
      wcol_q   <= 15'd0;
      pend_q   <= 8'd0;
      dcol_q   <= 15'd0;
      row_q    <= 15'd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      mbytes_q <= mbytes_d;
      mcnt_q   <= mcnt_d;
      ch_q     <= ch_d;
      wcol_q   <= wcol_d;
      pend_q   <= pend_d;
      dcol_q   <= dcol_d;
      row_q    <= row_d;
      ov_q     <= ov_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == hrle_pkg::CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    scol_q  <= scol_d;
    srow_q  <= srow_d;
    slr_q   <= slr_d;
    sli_q   <= sli_d;
    oerr_q  <= oerr_d;
    orgbe_q <= orgbe_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    olr_q   <= olr_d;
    oli_q   <= oli_d;
  end

  assign out_valid_o = ov_q;
  assign out_err_o   = oerr_q;
  assign out_red_o   = orgbe_q[7:0];
  assign out_green_o = orgbe_q[15:8];
  assign out_blue_o  = orgbe_q[23:16];
  assign out_exp_o   = orgbe_q[31:24];
  assign out_col_o   = ocol_q;
  assign out_row_o   = orow_q;
  assign out_lr_o    = olr_q;
  assign out_li_o    = oli_q;

endmodule
`default_nettype wire

### rtl/core/hdr_rle_scanline_decoder.sv
// Top level of the adaptive RLE RGBE scanline decoder.
`default_nettype none
// Decodes adaptive run-length encoded RGBE pixel data, one stream byte per
// item (tuser = 0), into a four-plane line store, then hands out one
// interleaved pixel per drain tick (tuser = 1) with its row and column.
// A run value byte starts a fill of the run length (1 to 127 entries) in
// which one store entry is written per cycle through the shared column
// adder, and the block is not ready meanwhile. After a drain tick the
// block waits for the registered store read and is not ready meanwhile.
// The line store has no reset: each row is written before it is drained.
// A bad marker, a zero or overflowing count, or a byte during drain gives
// one error result, after which all items are taken and dropped until reset.
module hdr_rle_scanline_decoder #(
  parameter int unsigned MAX_WIDTH = hrle_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  wire logic        s_axis_tuser,  // [0] kind
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] error_code, [10:3] red, [18:11] green, [26:19] blue,
  // [34:27] exponent, [49:35] column, [64:50] row, [71:65] zero
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tlast,  // last_in_row
  output logic             m_axis_tuser   // [0] last_in_image
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [14:0]          colu_width;
  hrle_pkg::colu_req_t  colu_req;
  hrle_pkg::colu_rsp_t  colu_rsp;
  hrle_pkg::store_req_t store;
  logic [31:0]          store_rdata;

  logic [2:0]  err;
  logic [7:0]  red, green, blue, expo;
  logic [14:0] col, row;

  hrle_col_unit u_colu (
    .width_i (colu_width),
    .req_i   (colu_req),
    .rsp_o   (colu_rsp)
  );

  hrle_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_err_o     (err),
    .out_red_o     (red),
    .out_green_o   (green),
    .out_blue_o    (blue),
    .out_exp_o     (expo),
    .out_col_o     (col),
    .out_row_o     (row),
    .out_lr_o      (m_axis_tlast),
    .out_li_o      (m_axis_tuser),
    .colu_width_o  (colu_width),
    .colu_req_o    (colu_req),
    .colu_rsp_i    (colu_rsp),
    .store_o       (store),
    .store_rdata_i (store_rdata)
  );

  // one store plane per channel, read side by side during drain
  for (genvar g = 0; g < 4; g++) begin : g_plane
    hrle_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (store.we[g]),
      .waddr_i (store.waddr[AW-1:0]),
      .wdata_i (store.wdata),
      .raddr_i (store.raddr[AW-1:0]),
      .rdata_o (store_rdata[8*g +: 8])
    );
  end

  assign m_axis_tdata = {7'd0, row, col, expo, blue, green, red, err};

endmodule
`default_nettype wire

### tb/hdr_rle_scanline_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RLE RGBE scanline decoder: scoreboard, stimulus, checks.
module hdr_rle_scanline_decoder_tb;

  localparam int unsigned PLANE_DEPTH   = hrle_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_RUN       = 127;
  localparam int unsigned MAX_LIT       = 128;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned SETTLE_CYCLES = 140;   // longest run fill plus margin
  localparam int unsigned IDLE_LIMIT    = 5000;  // cycles without any handshake
  localparam int unsigned HOLD_OFF      = 300;   // receiver back-pressure stretch
  localparam int unsigned MAX_REPORTS   = 20;

  typedef enum logic [2:0] {
    DEC_MARKER,
    DEC_CODE,
    DEC_RUN,
    DEC_LIT,
    DEC_DRAIN,
    DEC_HALT
  } dec_phase_e;

  typedef struct packed {
    logic [2:0]  code;
    logic [7:0]  red, green, blue, expo;
    logic [14:0] col, row;
    logic        last_row, last_img;
  } pixel_t;

  // Decoder model plus the queue of pixels and errors it still expects
  class PixelScoreboard;
    logic [14:0] width_reg, height_reg;
    dec_phase_e  phase;
    logic [23:0] marker_sr;
    int unsigned marker_cnt, plane_sel, wr_col, chunk_left, rd_col;
    logic [14:0] row_cnt;
    logic [7:0]  plane [4][PLANE_DEPTH];
    pixel_t      pending_q[$];
    int unsigned mismatches, checked;

    function new();
      width_reg  = 15'(hrle_pkg::MIN_WIDTH);
      height_reg = 15'd1;
      phase      = DEC_MARKER;
      marker_sr  = '0;
      marker_cnt = 0;
      plane_sel  = 0;
      wr_col     = 0;
      chunk_left = 0;
      rd_col     = 0;
      row_cnt    = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned row_width();
      return (width_reg < hrle_pkg::MIN_WIDTH) ? hrle_pkg::MIN_WIDTH : int'(width_reg);
    endfunction

    function void set_reg(logic idx, logic [14:0] val);
      if (idx == hrle_pkg::CFG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void put(int unsigned ch, int unsigned col, logic [7:0] val);
      if (col < PLANE_DEPTH) plane[ch][col] = val;
    endfunction

    // Error result carries only the code; the decoder then stays halted
    function void fail_with(logic [2:0] code);
      pixel_t r;
      r = '0;
      r.code = code;
      pending_q.push_back(r);
      phase = DEC_HALT;
    endfunction

    // End of a run or literal: next channel, drain, or next code
    function void close_chunk();
      if (wr_col >= row_width()) begin
        wr_col = 0;
        if (plane_sel >= 3) begin
          plane_sel = 0;
          rd_col = 0;
          phase = DEC_DRAIN;
          return;
        end
        plane_sel++;
      end
      phase = DEC_CODE;
    endfunction

    function void note_input(logic kind, logic [7:0] b);
      int unsigned w, h, room, cnt;
      pixel_t r;
      w = row_width();
      h = (height_reg == 0) ? 1 : int'(height_reg);
      if (phase == DEC_HALT) return;

      // Drain tick: one interleaved pixel, ignored outside the drain
      if (kind == hrle_pkg::KIND_TICK) begin
        if (phase != DEC_DRAIN) return;
        r.code     = hrle_pkg::RES_PIXEL;
        r.red      = plane[0][rd_col];
        r.green    = plane[1][rd_col];
        r.blue     = plane[2][rd_col];
        r.expo     = plane[3][rd_col];
        r.col      = rd_col[14:0];
        r.row      = row_cnt;
        r.last_row = (rd_col + 1 >= w);
        r.last_img = r.last_row && (int'(row_cnt) + 1 >= h);
        pending_q.push_back(r);
        if (r.last_row) begin
          row_cnt    = r.last_img ? 15'd0 : row_cnt + 15'd1;
          rd_col     = 0;
          marker_sr  = '0;
          marker_cnt = 0;
          phase      = DEC_MARKER;
        end else begin
          rd_col++;
        end
        return;
      end

      room = (w > wr_col) ? w - wr_col : 0;
      case (phase)
        DEC_MARKER: begin
          if (marker_cnt < 3) begin
            marker_sr = {marker_sr[15:0], b};
            marker_cnt++;
          end else begin
            marker_cnt = 0;
            if (marker_sr[23:16] != hrle_pkg::MARKER_BYTE ||
                marker_sr[15:8] != hrle_pkg::MARKER_BYTE ||
                {marker_sr[7:0], b} != w) begin
              marker_sr = '0;
              fail_with(hrle_pkg::RES_BAD_MARKER);
            end else begin
              marker_sr = '0;
              plane_sel = 0;
              wr_col    = 0;
              phase     = DEC_CODE;
            end
          end
        end
        DEC_CODE: begin
          if (b > hrle_pkg::RUN_BASE) begin
            cnt = b - hrle_pkg::RUN_BASE;
            if (cnt > room) begin
              fail_with(hrle_pkg::RES_BAD_RUN);
            end else begin
              chunk_left = cnt;
              phase = DEC_RUN;
            end
          end else begin
            cnt = b;
            if (cnt == 0 || cnt > room) begin
              fail_with(hrle_pkg::RES_BAD_LIT);
            end else begin
              chunk_left = cnt;
              phase = DEC_LIT;
            end
          end
        end
        DEC_RUN: begin
          for (int unsigned i = 0; i < chunk_left; i++) put(plane_sel, wr_col + i, b);
          wr_col += chunk_left;
          chunk_left = 0;
          close_chunk();
        end
        DEC_LIT: begin
          put(plane_sel, wr_col, b);
          wr_col++;
          if (chunk_left > 0) chunk_left--;
          if (chunk_left == 0) close_chunk();
        end
        DEC_DRAIN: fail_with(hrle_pkg::RES_BYTE_DRAIN);
        default: phase = DEC_HALT;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
    endtask

    task check_result(logic [71:0] d, logic last_row, logic last_img);
      pixel_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing expected, tdata=%h", d));
        return;
      end
      e = pending_q.pop_front();
      compare_field("error_code", d[2:0], e.code);
      compare_field("red", d[10:3], e.red);
      compare_field("green", d[18:11], e.green);
      compare_field("blue", d[26:19], e.blue);
      compare_field("exponent", d[34:27], e.expo);
      compare_field("column", d[49:35], e.col);
      compare_field("row", d[64:50], e.row);
      compare_field("last_in_row", last_row, e.last_row);
      compare_field("last_in_image", last_img, e.last_img);
      checked++;
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [14:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  wire         cfg_ready_o;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [71:0] m_axis_tdata;
  wire         m_axis_tlast;
  wire         m_axis_tuser;

  PixelScoreboard sb;
  bit          steady;      // no idling on either side
  bit          squeeze;     // next drain starts with a receiver hold-off
  int unsigned hold_cycles;
  int unsigned n_bytes, n_ticks, n_settings;
  int unsigned idle_cnt;

  hdr_rle_scanline_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Result side: check accepted items, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog on stretches with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, b);
  endtask

  // Data byte, now and then preceded by a stray tick (dropped outside the drain)
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 3) send_item(hrle_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    send_item(hrle_pkg::KIND_BYTE, b);
    n_bytes++;
  endtask

  task automatic send_marker(input int unsigned w);
    send_byte(hrle_pkg::MARKER_BYTE);
    send_byte(hrle_pkg::MARKER_BYTE);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  function automatic int unsigned pick_count(int unsigned room, int unsigned cap, bit big);
    int unsigned lim;
    lim = (room < cap) ? room : cap;
    if (big || $urandom_range(0, 7) == 0) return lim;
    return $urandom_range(1, lim);
  endfunction

  // Well-formed scanline with random runs and literals, then some drain ticks
  task automatic send_row(input int unsigned w, input bit big, input int unsigned ticks);
    int unsigned col, cnt;
    send_marker(w);
    for (int ch = 0; ch < 4; ch++) begin
      col = 0;
      while (col < w) begin
        if (big ? ($urandom_range(0, 99) < 97) : ($urandom_range(0, 1) == 1)) begin
          cnt = pick_count(w - col, MAX_RUN, big);
          send_byte(8'(hrle_pkg::RUN_BASE + cnt));
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          cnt = pick_count(w - col, MAX_LIT, big);
          send_byte(8'(cnt));
          repeat (cnt) send_byte(8'($urandom_range(0, 255)));
        end
        col += cnt;
      end
    end
    if (squeeze) begin
      squeeze = 0;
      hold_cycles = HOLD_OFF;
    end
    repeat (ticks) begin
      send_item(hrle_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
      n_ticks++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [14:0] w, input logic [14:0] h);
    write_reg(hrle_pkg::CFG_WIDTH, w);
    write_reg(hrle_pkg::CFG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Stop offering, wait for all expected results, let the block settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w, rows, sel, base, err_kind, phase_no;
    logic [14:0] w_reg, h_reg;
    logic [7:0]  v;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick outside drain, zero height, width shrunk in the middle of a run
    send_item(hrle_pkg::KIND_TICK, 8'hFF);
    s_axis_tvalid <= 1'b0;
    configure(15'd12, 15'd0);
    send_marker(12);
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'(hrle_pkg::RUN_BASE + 9));
    s_axis_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(hrle_pkg::CFG_WIDTH, 15'd8);
    cfg_valid_i <= 1'b0;
    // run overshoots the new width and closes the red channel
    send_byte(8'hA5);
    send_byte(8'(hrle_pkg::RUN_BASE + 8));
    send_byte(8'hFF);
    send_byte(8'd1);
    send_byte(8'h3C);
    send_byte(8'(hrle_pkg::RUN_BASE + 7));
    send_byte(8'h80);
    send_byte(8'(hrle_pkg::RUN_BASE + 8));
    send_byte(8'h00);  // black exponent
    repeat (8) begin
      send_item(hrle_pkg::KIND_TICK, 8'h00);
      n_ticks++;
    end
    quiesce();

    // Random scanlines under changing register settings
    base = n_bytes + n_ticks;
    phase_no = 0;
    while (n_bytes + n_ticks - base < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) w_reg = 15'($urandom_range(0, 7));
      else if (sel < 75) w_reg = 15'($urandom_range(8, 24));
      else if (sel < 92) w_reg = 15'($urandom_range(25, 64));
      else w_reg = 15'($urandom_range(100, 300));
      sel = $urandom_range(0, 9);
      if (sel < 6) h_reg = 15'($urandom_range(0, 3));
      else if (sel < 9) h_reg = 15'($urandom_range(4, 9));
      else h_reg = 15'h7FFF;
      if (phase_no == 1) begin
        w_reg = 15'd64;
        squeeze = 1;
      end
      steady = (phase_no == 3);
      configure(w_reg, h_reg);
      w = (w_reg < hrle_pkg::MIN_WIDTH) ? hrle_pkg::MIN_WIDTH : int'(w_reg);
      rows = $urandom_range(1, 4);
      repeat (rows) send_row(w, 0, w);
      quiesce();
      steady = 0;
      phase_no++;
    end

    // Closing error case; the decoder must halt and drop everything after it
    w = $urandom_range(8, 20);
    configure(15'(w), 15'($urandom_range(1, 3)));
    err_kind = $urandom_range(0, 6);
    case (err_kind)
      0: begin
        v = 8'($urandom_range(0, 254));
        if (v >= hrle_pkg::MARKER_BYTE) v++;
        send_byte(v);
        send_byte(hrle_pkg::MARKER_BYTE);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
      end
      1: begin
        v = 8'($urandom_range(0, 254));
        if (v >= hrle_pkg::MARKER_BYTE) v++;
        send_byte(hrle_pkg::MARKER_BYTE);
        send_byte(v);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
      end
      2: begin
        send_byte(hrle_pkg::MARKER_BYTE);
        send_byte(hrle_pkg::MARKER_BYTE);
        send_byte(w[15:8]);
        send_byte(w[7:0] ^ 8'($urandom_range(1, 255)));
      end
      3: begin
        send_marker(w);
        send_byte(8'(hrle_pkg::RUN_BASE + 1));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'(hrle_pkg::RUN_BASE + $urandom_range(w, MAX_RUN)));
      end
      4: begin
        send_marker(w);
        send_byte(8'd0);
      end
      5: begin
        send_marker(w);
        send_byte(8'd1);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(w, MAX_LIT)));
      end
      default: begin
        send_row(w, 0, $urandom_range(0, w - 1));
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (16) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    quiesce();

    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_q.size()));
    $display("Run covered %0d data bytes and %0d drain ticks over %0d register settings,",
             n_bytes, n_ticks, n_settings);
    $display("widths 8 to 300; %0d results checked, closing error case %0d.",
             sb.checked, err_kind);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
